>>> rtl/core/mewd_pkg.sv
// Package with shared types, character codes and digit decoders for the encoded-word decoder.
`default_nettype none
package mewd_pkg;

  // Character codes used by the framing and text decoders.
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_LOW_Q  = 8'h71;
  localparam logic [7:0] CH_UP_Q   = 8'h51;

  // Parsing phases.
  localparam logic [2:0] PH_OPEN_EQ  = 3'd0;
  localparam logic [2:0] PH_OPEN_Q   = 3'd1;
  localparam logic [2:0] PH_CHARSET  = 3'd2;
  localparam logic [2:0] PH_ENC      = 3'd3;
  localparam logic [2:0] PH_TEXT     = 3'd4;
  localparam logic [2:0] PH_CLOSE_EQ = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_CHARSET = 2'd0;
  localparam logic [1:0] KIND_DECODED = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Escape progress in Q-encoding.
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // Saturation limits and the question-mark count of a good token.
  localparam logic [2:0] QCOUNT_MAX  = 3'd7;
  localparam logic [2:0] QCOUNT_GOOD = 3'd4;
  localparam logic [1:0] ENC_LEN_MAX = 2'd3;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] question_count;
    logic       error_seen;
    logic       use_base64;
    logic [1:0] encoding_field_length;
    logic [1:0] base64_position;
    logic [5:0] base64_leftover;
    logic       base64_padding_seen;
    logic [1:0] escape_position;
    logic [3:0] escape_high_nibble;
  } state_t;

  // Result of one decode step.
  typedef struct packed {
    logic       have;
    logic [1:0] kind;
    logic [7:0] value;
    logic       status;
    logic       last;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_OPEN_EQ, question_count: 3'd0, error_seen: 1'b0, use_base64: 1'b0,
    encoding_field_length: 2'd0, base64_position: 2'd0, base64_leftover: 6'd0,
    base64_padding_seen: 1'b0, escape_position: ESC_IDLE, escape_high_nibble: 4'd0
  };

  // Hex digit: bit 4 is the valid flag, bits 3:0 the nibble.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Base64 digit: bit 6 is the valid flag, bits 5:0 the digit value.
  function automatic logic [6:0] b64_digit(input logic [7:0] c);
    logic [6:0] r;
    logic [7:0] t;
    r = 7'd0;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h47;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'h04;
      r = {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/mewd_step.sv
// Combinational decode step: next decoder state and result for one byte.
`default_nettype none
module mewd_step (
  input  wire logic [7:0]      byte_in,
  input  wire logic            final_byte,
  input  wire mewd_pkg::state_t cur,
  output mewd_pkg::state_t     nxt,
  output mewd_pkg::result_t    res
);

  logic [4:0] hex;
  logic [6:0] b64;
  logic [3:0] nib;
  logic       bad;
  mewd_pkg::state_t upd;

  assign hex = mewd_pkg::hex_digit(byte_in);
  assign b64 = mewd_pkg::b64_digit(byte_in);
  assign nib = hex[4] ? hex[3:0] : 4'd0;

  // Framing, encoding field and text decode.
  always_comb begin
    upd = cur;
    res = '0;
    res.kind = mewd_pkg::KIND_CHARSET;

    if (byte_in == mewd_pkg::CH_QMARK && cur.question_count != mewd_pkg::QCOUNT_MAX) begin
      upd.question_count = cur.question_count + 3'd1;
    end

    case (cur.phase)
      mewd_pkg::PH_OPEN_EQ: begin
        if (byte_in != mewd_pkg::CH_EQUALS) upd.error_seen = 1'b1;
        upd.phase = mewd_pkg::PH_OPEN_Q;
      end
      mewd_pkg::PH_OPEN_Q: begin
        if (byte_in != mewd_pkg::CH_QMARK) upd.error_seen = 1'b1;
        upd.phase = mewd_pkg::PH_CHARSET;
      end
      mewd_pkg::PH_CHARSET: begin
        if (byte_in == mewd_pkg::CH_QMARK) begin
          upd.phase = mewd_pkg::PH_ENC;
        end else begin
          res.have  = 1'b1;
          res.kind  = mewd_pkg::KIND_CHARSET;
          res.value = byte_in;
        end
      end
      mewd_pkg::PH_ENC: begin
        if (byte_in == mewd_pkg::CH_QMARK) begin
          if (cur.encoding_field_length != 2'd1) upd.error_seen = 1'b1;
          upd.phase = mewd_pkg::PH_TEXT;
        end else begin
          if (cur.encoding_field_length == 2'd0) begin
            if (byte_in == mewd_pkg::CH_UP_B || byte_in == mewd_pkg::CH_LOW_B) begin
              upd.use_base64 = 1'b1;
            end else if (byte_in == mewd_pkg::CH_UP_Q || byte_in == mewd_pkg::CH_LOW_Q) begin
              upd.use_base64 = 1'b0;
            end else begin
              upd.error_seen = 1'b1;
            end
          end
          if (cur.encoding_field_length != mewd_pkg::ENC_LEN_MAX) begin
            upd.encoding_field_length = cur.encoding_field_length + 2'd1;
          end
        end
      end
      mewd_pkg::PH_TEXT: begin
        res.kind = mewd_pkg::KIND_DECODED;
        if (byte_in == mewd_pkg::CH_QMARK) begin
          if (cur.escape_position != mewd_pkg::ESC_IDLE) upd.error_seen = 1'b1;
          if (cur.use_base64 && cur.base64_position != 2'd0) upd.error_seen = 1'b1;
          upd.phase = mewd_pkg::PH_CLOSE_EQ;
        end else if (!cur.use_base64) begin
          // Q-encoding: escapes, underscores and literal bytes.
          if (cur.escape_position != mewd_pkg::ESC_IDLE) begin
            if (!hex[4]) upd.error_seen = 1'b1;
            if (cur.escape_position == mewd_pkg::ESC_HIGH) begin
              upd.escape_high_nibble = nib;
              upd.escape_position    = mewd_pkg::ESC_LOW;
            end else begin
              upd.escape_position = mewd_pkg::ESC_IDLE;
              res.have  = 1'b1;
              res.value = {cur.escape_high_nibble, nib};
            end
          end else if (byte_in == mewd_pkg::CH_EQUALS) begin
            upd.escape_position = mewd_pkg::ESC_HIGH;
          end else begin
            res.have  = 1'b1;
            res.value = (byte_in == mewd_pkg::CH_UNDER) ? mewd_pkg::CH_SPACE : byte_in;
          end
        end else if (byte_in == mewd_pkg::CH_EQUALS) begin
          // Base64 padding.
          if (cur.base64_position == 2'd2 && !cur.base64_padding_seen) begin
            upd.base64_padding_seen = 1'b1;
            upd.base64_position     = 2'd3;
          end else if (cur.base64_position == 2'd3 && cur.base64_padding_seen) begin
            upd.base64_position = 2'd0;
          end else if (cur.base64_position == 2'd3) begin
            upd.base64_padding_seen = 1'b1;
            upd.base64_position     = 2'd0;
          end else begin
            upd.error_seen = 1'b1;
          end
        end else if (!b64[6] || cur.base64_padding_seen) begin
          upd.error_seen = 1'b1;
        end else begin
          // Base64 data digit: combine with the bits left from the last one.
          case (cur.base64_position)
            2'd0: begin
              upd.base64_leftover = b64[5:0];
              upd.base64_position = 2'd1;
            end
            2'd1: begin
              res.have  = 1'b1;
              res.value = {cur.base64_leftover, b64[5:4]};
              upd.base64_leftover = {2'd0, b64[3:0]};
              upd.base64_position = 2'd2;
            end
            2'd2: begin
              res.have  = 1'b1;
              res.value = {cur.base64_leftover[3:0], b64[5:2]};
              upd.base64_leftover = {4'd0, b64[1:0]};
              upd.base64_position = 2'd3;
            end
            default: begin
              res.have  = 1'b1;
              res.value = {cur.base64_leftover[1:0], b64[5:0]};
              upd.base64_leftover = 6'd0;
              upd.base64_position = 2'd0;
            end
          endcase
        end
      end
      mewd_pkg::PH_CLOSE_EQ: begin
        if (byte_in != mewd_pkg::CH_EQUALS) upd.error_seen = 1'b1;
        upd.phase = mewd_pkg::PH_DONE;
      end
      default: begin
        upd.error_seen = 1'b1;
      end
    endcase

    // The last byte of a token replaces any byte result with the status.
    bad = upd.error_seen || upd.phase != mewd_pkg::PH_DONE ||
          upd.question_count != mewd_pkg::QCOUNT_GOOD;
    nxt = upd;
    if (final_byte) begin
      nxt        = mewd_pkg::STATE_RESET;
      res.have   = 1'b1;
      res.kind   = mewd_pkg::KIND_STATUS;
      res.value  = 8'd0;
      res.status = bad;
      res.last   = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mime_encoded_word_decoder_core.sv
// Top level of the encoded-word decoder: input register, decode step, result register.
//
// Usage: feed one token "=?charset?E?text?=" a byte per transaction on the input
// channel (byte_in, final_byte; final_byte marks the last byte). Each transaction
// yields zero or one result transaction on the output channel: charset bytes
// (kind 0), decoded text bytes (kind 1), and on the last byte one status result
// (kind 2, last = 1, status = 1 on any format or decode error). On an error
// status the consumer discards the results already delivered for that token.
// A result moves from the input register through the combinational decode step,
// which also updates the decoder state, into the result register. Throughput:
// one byte per cycle while the receiver does not stall a result that is ready
// to be stored, set by the decode step between the two registers.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// the start of a token. When the receiver stalls, the result register holds;
// bytes that produce no result still move on, and in_stall rises only while
// the input register holds a byte whose result cannot yet be stored.
`default_nettype none
module mime_encoded_word_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      value,
  output logic            status,
  output logic            last
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              hold_final;
  mewd_pkg::state_t  state;
  mewd_pkg::state_t  state_next;
  mewd_pkg::result_t step_res;
  logic              advance;

  mewd_step u_step (
    .byte_in    (hold_byte),
    .final_byte (hold_final),
    .cur        (state),
    .nxt        (state_next),
    .res        (step_res)
  );

  // The held byte moves on unless it has a result and the result register is blocked.
  assign advance  = hold_valid && (!step_res.have || !out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      hold_byte  <= byte_in;
      hold_final <= final_byte;
    end
  end

  // Decoder state, updated as each byte passes the decode step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mewd_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.have) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.have) begin
      kind   <= step_res.kind;
      value  <= step_res.value;
      status <= step_res.status;
      last   <= step_res.last;
    end
  end

  // Checks on the decoder's own logic.
  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == 1'b0 && kind != mewd_pkg::KIND_STATUS)
    else $error("byte result carries status or status kind");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind == mewd_pkg::KIND_STATUS && value == 8'd0)
    else $error("last result is not a clean status");

  a_token_restart: assert property (@(posedge clk) disable iff (rst)
    advance && hold_final |=> state.phase == mewd_pkg::PH_OPEN_EQ &&
                              state.question_count == 3'd0 && !state.error_seen)
    else $error("decoder state not restarted after last byte");

  a_stall_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && step_res.have)
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

>>> verif/mewd_checker.sv
// Checker for the encoded-word decoder: predicts results from accepted bytes and compares them.
`timescale 1ns / 100ps
module mewd_checker
  import mewd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       final_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  input  logic       status,
  input  logic       last,
  output int         fail_count,
  output int         pending
);

  // One expected result transaction.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       status;
    logic       last;
  } decoded_item_t;

  decoded_item_t expected_results[$];
  int            results_seen;

  // Predicted decoder state.
  logic [2:0] stage;
  logic [2:0] qmarks;
  logic       bad;
  logic       b64_mode;
  logic [1:0] enc_len;
  logic [1:0] grp_pos;
  logic [5:0] carry_bits;
  logic       pad_seen;
  logic [1:0] esc_pos;
  logic [3:0] esc_hi;

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

  task automatic report_failure(input string msg);
    if (fail_count < 100) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Returns {valid, nibble}; the nibble is zero for a non-hex character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else begin
      return 5'd0;
    end
    return {1'b1, d[3:0]};
  endfunction

  // Returns {valid, sextet} for a base64 alphabet character.
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else begin
      return 7'd0;
    end
    return {1'b1, d[5:0]};
  endfunction

  task automatic clear_decoder();
    stage = PH_OPEN_EQ;
    qmarks = 3'd0;
    bad = 1'b0;
    b64_mode = 1'b0;
    enc_len = 2'd0;
    grp_pos = 2'd0;
    carry_bits = 6'd0;
    pad_seen = 1'b0;
    esc_pos = ESC_IDLE;
    esc_hi = 4'd0;
  endtask

  // Advances the predicted state by one byte and queues the result it causes.
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    logic          emit;
    logic [1:0]    k;
    logic [7:0]    v;
    logic [4:0]    hx;
    logic [6:0]    bd;
    decoded_item_t item;
    emit = 1'b0;
    k = KIND_CHARSET;
    v = 8'd0;
    if (c == CH_QMARK && qmarks != QCOUNT_MAX) qmarks = qmarks + 3'd1;

    case (stage)
      PH_OPEN_EQ: begin
        if (c != CH_EQUALS) bad = 1'b1;
        stage = PH_OPEN_Q;
      end
      PH_OPEN_Q: begin
        if (c != CH_QMARK) bad = 1'b1;
        stage = PH_CHARSET;
      end
      PH_CHARSET: begin
        if (c == CH_QMARK) begin
          stage = PH_ENC;
        end else begin
          emit = 1'b1;
          k = KIND_CHARSET;
          v = c;
        end
      end
      PH_ENC: begin
        if (c == CH_QMARK) begin
          if (enc_len != 2'd1) bad = 1'b1;
          stage = PH_TEXT;
        end else begin
          // Only the first letter of the field picks the encoding.
          if (enc_len == 2'd0) begin
            if (c == CH_UP_B || c == CH_LOW_B) begin
              b64_mode = 1'b1;
            end else if (c == CH_UP_Q || c == CH_LOW_Q) begin
              b64_mode = 1'b0;
            end else begin
              bad = 1'b1;
            end
          end
          if (enc_len != ENC_LEN_MAX) enc_len = enc_len + 2'd1;
        end
      end
      PH_TEXT: begin
        if (c == CH_QMARK) begin
          // A text that stops inside an escape or a base64 group is malformed.
          if (esc_pos != ESC_IDLE) bad = 1'b1;
          if (b64_mode && grp_pos != 2'd0) bad = 1'b1;
          stage = PH_CLOSE_EQ;
        end else if (!b64_mode) begin
          if (esc_pos != ESC_IDLE) begin
            hx = hex_value(c);
            if (!hx[4]) bad = 1'b1;
            if (esc_pos == ESC_HIGH) begin
              esc_hi = hx[3:0];
              esc_pos = ESC_LOW;
            end else begin
              esc_pos = ESC_IDLE;
              emit = 1'b1;
              k = KIND_DECODED;
              v = {esc_hi, hx[3:0]};
            end
          end else if (c == CH_EQUALS) begin
            esc_pos = ESC_HIGH;
          end else begin
            emit = 1'b1;
            k = KIND_DECODED;
            v = (c == CH_UNDER) ? CH_SPACE : c;
          end
        end else if (c == CH_EQUALS) begin
          // Padding is legal only in the third and fourth places of a group.
          if (grp_pos == 2'd2 && !pad_seen) begin
            pad_seen = 1'b1;
            grp_pos = 2'd3;
          end else if (grp_pos == 2'd3 && pad_seen) begin
            grp_pos = 2'd0;
          end else if (grp_pos == 2'd3) begin
            pad_seen = 1'b1;
            grp_pos = 2'd0;
          end else begin
            bad = 1'b1;
          end
        end else begin
          bd = b64_value(c);
          if (!bd[6] || pad_seen) begin
            bad = 1'b1;
          end else begin
            k = KIND_DECODED;
            emit = (grp_pos != 2'd0);
            case (grp_pos)
              2'd0: carry_bits = bd[5:0];
              2'd1: begin
                v = {carry_bits, bd[5:4]};
                carry_bits = {2'b00, bd[3:0]};
              end
              2'd2: begin
                v = {carry_bits[3:0], bd[5:2]};
                carry_bits = {4'b0000, bd[1:0]};
              end
              default: begin
                v = {carry_bits[1:0], bd[5:0]};
                carry_bits = 6'd0;
              end
            endcase
            grp_pos = grp_pos + 2'd1;
          end
        end
      end
      PH_CLOSE_EQ: begin
        if (c != CH_EQUALS) bad = 1'b1;
        stage = PH_DONE;
      end
      default: bad = 1'b1;
    endcase

    // The last byte yields only the status and starts a new token.
    if (fin) begin
      item.kind = KIND_STATUS;
      item.value = 8'd0;
      item.status = bad || stage != PH_DONE || qmarks != QCOUNT_GOOD;
      item.last = 1'b1;
      expected_results.push_back(item);
      clear_decoder();
    end else if (emit) begin
      item.kind = k;
      item.value = v;
      item.status = 1'b0;
      item.last = 1'b0;
      expected_results.push_back(item);
    end
  endtask

  task automatic check_result();
    decoded_item_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_failure($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = expected_results.pop_front();
    if (kind != want.kind)
      report_failure($sformatf("result %0d kind %0d, expected %0d",
                               results_seen, kind, want.kind));
    if (value != want.value)
      report_failure($sformatf("result %0d value %02h, expected %02h",
                               results_seen, value, want.value));
    if (status != want.status)
      report_failure($sformatf("result %0d status %0b, expected %0b",
                               results_seen, status, want.status));
    if (last != want.last)
      report_failure($sformatf("result %0d last %0b, expected %0b",
                               results_seen, last, want.last));
  endtask

  // Results are checked before the new byte is predicted, so a result never
  // matches an expectation queued at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) decode_byte(byte_in, final_byte);
    end
    pending <= expected_results.size();
  end

endmodule

>>> verif/tb_top.sv
// Top of the encoded-word decoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import mewd_pkg::*;

  localparam int ITEMS       = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] byte_in;
  logic       final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic [7:0] value;
  logic       status;
  logic       last;

  int         fail_count;
  int         pending;
  int         send_pct;
  int         stall_pct;
  int         quiet_cycles;
  int         items_sent;
  logic [7:0] token[$];

  mime_encoded_word_decoder_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .status     (status),
    .last       (last)
  );

  mewd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .status     (status),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    byte_in = 8'd0;
    final_byte = 1'b0;
    out_stall = 1'b0;
    send_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
  end

  always #2 clk = ~clk;

  // Receiver stalls at random at the rate of the current idling phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] b64_char();
    int n;
    n = $urandom_range(63);
    if (n < 26) return 8'h41 + 8'(n);
    if (n < 52) return 8'h61 + 8'(n - 26);
    if (n < 62) return 8'h30 + 8'(n - 52);
    return (n == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] hex_char();
    int n;
    n = $urandom_range(21);
    if (n < 10) return 8'h30 + 8'(n);
    if (n < 16) return 8'h41 + 8'(n - 10);
    return 8'h61 + 8'(n - 16);
  endfunction

  // Bytes that matter to the decoder, mixed with arbitrary ones.
  function automatic logic [7:0] odd_char();
    case ($urandom_range(5))
      0:       return CH_QMARK;
      1:       return CH_EQUALS;
      2:       return CH_UNDER;
      3:       return b64_char();
      4:       return hex_char();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) token.push_back(s[i]);
  endtask

  // Builds a well-formed token with random charset, encoding and text.
  task automatic build_good_token();
    int         n;
    int         groups;
    logic [7:0] c;
    token.delete();
    token.push_back(CH_EQUALS);
    token.push_back(CH_QMARK);
    n = $urandom_range(4);
    repeat (n) begin
      c = 8'($urandom_range(255));
      token.push_back((c == CH_QMARK) ? CH_UNDER : c);
    end
    token.push_back(CH_QMARK);
    case ($urandom_range(3))
      0:       c = CH_UP_B;
      1:       c = CH_LOW_B;
      2:       c = CH_UP_Q;
      default: c = CH_LOW_Q;
    endcase
    token.push_back(c);
    token.push_back(CH_QMARK);
    if (c == CH_UP_B || c == CH_LOW_B) begin
      groups = $urandom_range(3);
      repeat (4 * groups) token.push_back(b64_char());
      // Pad the last group with one or two equals signs now and then.
      if (groups > 0) begin
        case ($urandom_range(2))
          0: token[token.size() - 1] = CH_EQUALS;
          1: begin
            token[token.size() - 1] = CH_EQUALS;
            token[token.size() - 2] = CH_EQUALS;
          end
          default: ;
        endcase
      end
    end else begin
      n = $urandom_range(8);
      repeat (n) begin
        case ($urandom_range(3))
          0: begin
            token.push_back(CH_EQUALS);
            token.push_back(hex_char());
            token.push_back(hex_char());
          end
          1: token.push_back(CH_UNDER);
          default: begin
            c = 8'($urandom_range(255));
            token.push_back((c == CH_QMARK || c == CH_EQUALS) ? CH_UNDER : c);
          end
        endcase
      end
    end
    token.push_back(CH_QMARK);
    token.push_back(CH_EQUALS);
  endtask

  // Breaks a token by one random edit.
  task automatic mutate_token();
    int idx;
    int n;
    idx = $urandom_range(token.size() - 1);
    case ($urandom_range(4))
      0: token[idx] = odd_char();
      1: if (token.size() > 1) token.delete(idx);
      2: token.insert(idx, odd_char());
      3: begin
        n = $urandom_range(3, 1);
        repeat (n) token.push_back(odd_char());
      end
      default: while (token.size() > idx + 1) void'(token.pop_back());
    endcase
  endtask

  task automatic build_noise_token();
    int n;
    token.delete();
    n = $urandom_range(6, 1);
    repeat (n) token.push_back(odd_char());
  endtask

  // Presents one byte and holds it until the transaction completes.
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= c;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_token();
    for (int i = 0; i < token.size(); i++) begin
      send_byte(token[i], i == token.size() - 1);
    end
    items_sent += token.size();
  endtask

  initial begin
    int pick;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: top charset byte and base64 with padding.
    token.delete();
    push_text("=?");
    token.push_back(8'hFF);
    push_text("?b?QQ==?=");
    send_token();
    // Directed: zero byte where the opening equals sign is due, then an early end.
    token.delete();
    token.push_back(8'h00);
    token.push_back(CH_QMARK);
    send_token();
    // Directed: Q-encoding with an underscore and a non-hex escape digit.
    token.delete();
    push_text("=?x?Q?_=4g?=");
    send_token();

    while (items_sent < ITEMS) begin
      case (items_sent * 4 / ITEMS)
        0: begin
          send_pct <= 0;
          stall_pct <= 0;
        end
        1: begin
          send_pct <= 74;
          stall_pct <= 0;
        end
        2: begin
          send_pct <= 0;
          stall_pct <= 74;
        end
        default: begin
          send_pct <= 26;
          stall_pct <= 26;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 75) begin
        build_good_token();
      end else if (pick < 95) begin
        build_good_token();
        mutate_token();
      end else begin
        build_noise_token();
      end
      send_token();
    end
    in_valid <= 1'b0;

    // Let the count of outstanding results catch up, then drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
